// File: design/rotation_matrix_to_quaternion_core_macros.svh
// Assertion macros shared by the rotation matrix to quaternion RTL.
`ifndef ROTATION_MATRIX_TO_QUATERNION_CORE_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_CORE_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define RMQ_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("rmq invariant violated");

// A consequence that holds in the same cycle as its cause.
`define RMQ_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rmq implication violated");

// A consequence that holds in the cycle after its cause.
`define RMQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rmq next-cycle implication violated");

`endif

// File: design/rmq_pkg.sv
// Shared constants, widths and types of the rotation matrix to quaternion core.
`default_nettype none
package rmq_pkg;
	localparam int FRAC_BITS = 16;
	localparam int FW = 18;
	// Numerators are sums or differences of two fields.
	localparam int NW = FW + 1;
	// Magnitude width of the root argument s.
	localparam int SW = ((FRAC_BITS > FW + 1) ? FRAC_BITS : FW + 1) + 1;
	localparam int RADW0 = SW + FRAC_BITS;
	localparam int RADW = RADW0 + (RADW0 % 2);
	localparam int ROOTW = RADW / 2;
	localparam int REMW = ROOTW + 2;
	localparam int DW = NW + FRAC_BITS + 1;
	localparam int DVW = ROOTW + 1;
	localparam int QB = FW;

	typedef enum logic [1:0] {
		SEL_X = 2'd0,
		SEL_Y = 2'd1,
		SEL_Z = 2'd2,
		SEL_W = 2'd3
	} sel_t;

	typedef struct packed {
		sel_t sel;
		logic signed [NW-1:0] na;
		logic signed [NW-1:0] nb;
		logic signed [NW-1:0] nc;
	} side_t;

	typedef struct packed {
		sel_t sel;
		logic rzero;
		logic [ROOTW-2:0] half;
		logic [2:0] negres;
		logic [2:0] nz;
	} dside_t;

	typedef struct packed {
		logic signed [FW-1:0] qx;
		logic signed [FW-1:0] qy;
		logic signed [FW-1:0] qz;
		logic signed [FW-1:0] qw;
		logic sat;
	} qout_t;
endpackage
`default_nettype wire

// File: design/rmq_sqrt.sv
// Pipelined integer square root, one root bit per stage, with side data.
`default_nettype none
module rmq_sqrt (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_v,
	input  logic [rmq_pkg::RADW-1:0] rad,
	input  rmq_pkg::side_t side_i,
	output logic out_v,
	output logic [rmq_pkg::ROOTW-1:0] root,
	output rmq_pkg::side_t side_o
);
	import rmq_pkg::*;

	logic v_s [1:ROOTW];
	logic [ROOTW-1:0] root_s [1:ROOTW];
	side_t side_s [1:ROOTW];
	logic [RADW-1:0] rad_s [1:ROOTW-1];
	logic [REMW-1:0] rem_s [1:ROOTW-1];

	for (genvar k = 0; k < ROOTW; k++) begin : g_stage
		logic cur_v;
		logic [RADW-1:0] cur_rad;
		logic [REMW-1:0] cur_rem;
		logic [ROOTW-1:0] cur_root;
		side_t cur_side;
		logic [REMW-1:0] rem_sh;
		logic [REMW-1:0] trial;
		logic ge;

		if (k == 0) begin : g_first
			assign cur_v = in_v;
			assign cur_rad = rad;
			assign cur_rem = '0;
			assign cur_root = '0;
			assign cur_side = side_i;
		end else begin : g_rest
			assign cur_v = v_s[k];
			assign cur_rad = rad_s[k];
			assign cur_rem = rem_s[k];
			assign cur_root = root_s[k];
			assign cur_side = side_s[k];
		end

		// Bring down the next two radicand bits and try root*4+1.
		assign rem_sh = {cur_rem[REMW-3:0], cur_rad[RADW-1 -: 2]};
		assign trial = {cur_root, 2'b01};
		assign ge = (rem_sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[k+1] <= {cur_root[ROOTW-2:0], ge};
				side_s[k+1] <= cur_side;
			end
		end

		if (k < ROOTW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rad_s[k+1] <= cur_rad << 2;
					rem_s[k+1] <= ge ? (rem_sh - trial) : rem_sh;
				end
			end
		end
	end

	assign out_v = v_s[ROOTW];
	assign root = root_s[ROOTW];
	assign side_o = side_s[ROOTW];
endmodule
`default_nettype wire

// File: design/rmq_div.sv
// Three-lane pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module rmq_div (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_v,
	input  logic [2:0][rmq_pkg::DW-1:0] num,
	input  logic [rmq_pkg::DVW-1:0] dv,
	input  rmq_pkg::dside_t side_i,
	output logic out_v,
	output logic [2:0][rmq_pkg::QB-1:0] quo,
	output logic [2:0] ovf,
	output rmq_pkg::dside_t side_o
);
	import rmq_pkg::*;

	logic v_s [1:QB];
	logic [2:0][QB-1:0] quo_s [1:QB];
	logic [2:0] ovf_s [1:QB];
	dside_t side_s [1:QB];
	logic [2:0][DW-1:0] rem_s [1:QB-1];
	logic [DVW-1:0] dv_s [1:QB-1];

	for (genvar k = 0; k < QB; k++) begin : g_stage
		localparam int I = QB - 1 - k;
		localparam bit FIRST = (k == 0);
		logic cur_v;
		logic [2:0][DW-1:0] cur_rem;
		logic [2:0][QB-1:0] cur_quo;
		logic [2:0] cur_ovf;
		logic [DVW-1:0] cur_dv;
		dside_t cur_side;
		logic [DW-1:0] dvx;
		logic [2:0][DW-1:0] nrem;
		logic [2:0][QB-1:0] nquo;
		logic [2:0] novf;

		if (k == 0) begin : g_first
			assign cur_v = in_v;
			assign cur_rem = num;
			assign cur_quo = '0;
			assign cur_ovf = '0;
			assign cur_dv = dv;
			assign cur_side = side_i;
		end else begin : g_rest
			assign cur_v = v_s[k];
			assign cur_rem = rem_s[k];
			assign cur_quo = quo_s[k];
			assign cur_ovf = ovf_s[k];
			assign cur_dv = dv_s[k];
			assign cur_side = side_s[k];
		end

		assign dvx = {{(DW-DVW){1'b0}}, cur_dv};

		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic ge;
			assign ge = ((cur_rem[l] >> I) >= dvx);
			assign nrem[l] = ge ? (cur_rem[l] - (dvx << I)) : cur_rem[l];
			assign nquo[l] = cur_quo[l] | (QB'(ge) << I);
			// The quotient does not fit in QB bits when the dividend reaches dv*2^QB.
			assign novf[l] = cur_ovf[l] | (FIRST && ((cur_rem[l] >> QB) >= dvx));
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k+1] <= nquo;
				ovf_s[k+1] <= novf;
				side_s[k+1] <= cur_side;
			end
		end

		if (k < QB - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= nrem;
					dv_s[k+1] <= cur_dv;
				end
			end
		end
	end

	assign out_v = v_s[QB];
	assign quo = quo_s[QB];
	assign ovf = ovf_s[QB];
	assign side_o = side_s[QB];
endmodule
`default_nettype wire

// File: design/rotation_matrix_to_quaternion_core.sv
// Top level of the rotation matrix to quaternion core.
// Pipeline: a word accepted while in_ready is high passes 1 setup stage, 18 root stages,
// 1 stage forming the dividends and 18 divider stages, then enters the output queue.
// Throughput: one word per cycle; in_ready drops only while both output slots are full.
// Reset: arst_n clears every valid bit and the output queue; data registers are not reset.
`default_nettype none
`include "rotation_matrix_to_quaternion_core_macros.svh"
module rotation_matrix_to_quaternion_core (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [rmq_pkg::FW-1:0] m00,
	input  logic signed [rmq_pkg::FW-1:0] m01,
	input  logic signed [rmq_pkg::FW-1:0] m02,
	input  logic signed [rmq_pkg::FW-1:0] m10,
	input  logic signed [rmq_pkg::FW-1:0] m11,
	input  logic signed [rmq_pkg::FW-1:0] m12,
	input  logic signed [rmq_pkg::FW-1:0] m20,
	input  logic signed [rmq_pkg::FW-1:0] m21,
	input  logic signed [rmq_pkg::FW-1:0] m22,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [rmq_pkg::FW-1:0] qx,
	output logic signed [rmq_pkg::FW-1:0] qy,
	output logic signed [rmq_pkg::FW-1:0] qz,
	output logic signed [rmq_pkg::FW-1:0] qw,
	output logic saturated
);
	import rmq_pkg::*;

	localparam logic signed [SW:0] ONE = (SW+1)'(1) << FRAC_BITS;
	localparam logic signed [FW-1:0] Q_MAX = {1'b0, {(FW-1){1'b1}}};
	localparam logic signed [FW-1:0] Q_MIN = {1'b1, {(FW-1){1'b0}}};
	localparam logic [QB-1:0] NEG_LIMIT = {1'b1, {(QB-1){1'b0}}};

	logic en;

	// Setup stage: branch choice, root argument and numerators.
	logic signed [FW+1:0] trace;
	logic signed [SW:0] s_w, s_x, s_y, s_z, s_sel;
	sel_t sel;
	side_t side_d;
	logic [RADW-1:0] rad_d;

	always_comb begin
		trace = (FW+2)'(m00) + (FW+2)'(m11) + (FW+2)'(m22);
		s_w = (SW+1)'(trace) + ONE;
		s_x = ONE + (SW+1)'(m00) - (SW+1)'(m11) - (SW+1)'(m22);
		s_y = ONE + (SW+1)'(m11) - (SW+1)'(m00) - (SW+1)'(m22);
		s_z = ONE + (SW+1)'(m22) - (SW+1)'(m00) - (SW+1)'(m11);
		// Diagonal ties fall through to the later element.
		if (trace > 0) begin
			sel = SEL_W;
		end else if (m00 > m11 && m00 > m22) begin
			sel = SEL_X;
		end else if (m11 > m22) begin
			sel = SEL_Y;
		end else begin
			sel = SEL_Z;
		end
		side_d.sel = sel;
		case (sel)
			SEL_W: begin
				s_sel = s_w;
				side_d.na = NW'(m21) - NW'(m12);
				side_d.nb = NW'(m02) - NW'(m20);
				side_d.nc = NW'(m10) - NW'(m01);
			end
			SEL_X: begin
				s_sel = s_x;
				side_d.na = NW'(m10) + NW'(m01);
				side_d.nb = NW'(m20) + NW'(m02);
				side_d.nc = NW'(m21) - NW'(m12);
			end
			SEL_Y: begin
				s_sel = s_y;
				side_d.na = NW'(m10) + NW'(m01);
				side_d.nb = NW'(m21) + NW'(m12);
				side_d.nc = NW'(m02) - NW'(m20);
			end
			default: begin
				s_sel = s_z;
				side_d.na = NW'(m20) + NW'(m02);
				side_d.nb = NW'(m21) + NW'(m12);
				side_d.nc = NW'(m10) - NW'(m01);
			end
		endcase
		if (s_sel > 0) begin
			rad_d = {{(RADW-SW-1){1'b0}}, s_sel} << FRAC_BITS;
		end else begin
			rad_d = '0;
		end
	end

	logic v_s1;
	side_t side_s1;
	logic [RADW-1:0] rad_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_d;
			rad_s1 <= rad_d;
		end
	end

	logic sq_v;
	logic [ROOTW-1:0] sq_root;
	side_t sq_side;

	rmq_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (v_s1),
		.rad    (rad_s1),
		.side_i (side_s1),
		.out_v  (sq_v),
		.root   (sq_root),
		.side_o (sq_side)
	);

	// Dividend stage: |N| * 2^FRAC_BITS + R over divisor 2R rounds to nearest.
	logic signed [NW-1:0] nsel [3];
	logic [2:0][DW-1:0] num_d;
	dside_t dside_d;

	always_comb begin
		logic [NW-1:0] mag;
		nsel[0] = sq_side.na;
		nsel[1] = sq_side.nb;
		nsel[2] = sq_side.nc;
		dside_d.sel = sq_side.sel;
		dside_d.rzero = (sq_root == '0);
		dside_d.half = sq_root[ROOTW-1:1];
		for (int l = 0; l < 3; l++) begin
			mag = nsel[l][NW-1] ? (~nsel[l] + NW'(1)) : nsel[l];
			dside_d.negres[l] = nsel[l][NW-1] ^ (sq_side.sel != SEL_W);
			dside_d.nz[l] = (nsel[l] != '0);
			num_d[l] = {1'b0, mag, {FRAC_BITS{1'b0}}} + DW'(sq_root);
		end
	end

	logic v_s2;
	logic [2:0][DW-1:0] num_s2;
	logic [DVW-1:0] dv_s2;
	dside_t dside_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= sq_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2 <= num_d;
			dv_s2 <= {sq_root, 1'b0};
			dside_s2 <= dside_d;
		end
	end

	logic dq_v;
	logic [2:0][QB-1:0] dq_quo;
	logic [2:0] dq_ovf;
	dside_t dq_side;

	rmq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (v_s2),
		.num    (num_s2),
		.dv     (dv_s2),
		.side_i (dside_s2),
		.out_v  (dq_v),
		.quo    (dq_quo),
		.ovf    (dq_ovf),
		.side_o (dq_side)
	);

	// Sign, clamp and placement of the four components.
	qout_t fin;
	logic signed [FW-1:0] lane_val [3];
	logic [2:0] lane_sat;
	logic signed [FW-1:0] half_ext;
	logic signed [FW-1:0] root_c;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (dq_side.rzero) begin
				lane_sat[l] = dq_side.nz[l];
				if (!dq_side.nz[l]) begin
					lane_val[l] = '0;
				end else begin
					lane_val[l] = dq_side.negres[l] ? Q_MIN : Q_MAX;
				end
			end else if (dq_side.negres[l]) begin
				lane_sat[l] = dq_ovf[l] || (dq_quo[l] > NEG_LIMIT);
				lane_val[l] = lane_sat[l] ? Q_MIN : (~dq_quo[l] + QB'(1));
			end else begin
				lane_sat[l] = dq_ovf[l] || dq_quo[l][QB-1];
				lane_val[l] = lane_sat[l] ? Q_MAX : dq_quo[l];
			end
		end
		half_ext = FW'(dq_side.half);
		root_c = (dq_side.sel != SEL_W) ? (~half_ext + FW'(1)) : half_ext;
		fin.sat = dq_side.rzero | (|lane_sat);
		case (dq_side.sel)
			SEL_W: begin
				fin.qw = root_c;
				fin.qx = lane_val[0];
				fin.qy = lane_val[1];
				fin.qz = lane_val[2];
			end
			SEL_X: begin
				fin.qx = root_c;
				fin.qy = lane_val[0];
				fin.qz = lane_val[1];
				fin.qw = lane_val[2];
			end
			SEL_Y: begin
				fin.qy = root_c;
				fin.qx = lane_val[0];
				fin.qz = lane_val[1];
				fin.qw = lane_val[2];
			end
			default: begin
				fin.qz = root_c;
				fin.qx = lane_val[0];
				fin.qy = lane_val[1];
				fin.qw = lane_val[2];
			end
		endcase
	end

	// Two-slot output queue; the pipeline moves whenever a slot is free.
	qout_t fifo_q [2];
	logic wr_q;
	logic rd_q;
	logic [1:0] cnt_q;
	logic push;
	logic pop;

	assign en = (cnt_q != 2'd2);
	assign in_ready = en;
	assign push = dq_v && en;
	assign out_valid = (cnt_q != 2'd0);
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= fin;
		end
	end

	assign qx = fifo_q[rd_q].qx;
	assign qy = fifo_q[rd_q].qy;
	assign qz = fifo_q[rd_q].qz;
	assign qw = fifo_q[rd_q].qw;
	assign saturated = fifo_q[rd_q].sat;

	`RMQ_ASSERT_ALWAYS(a_cnt_range, cnt_q != 2'd3)
	`RMQ_ASSERT_IMPL(a_rzero_sat, dq_v && dq_side.rzero, fin.sat)
	`RMQ_ASSERT_NEXT(a_push_count, push && !pop, cnt_q == $past(cnt_q) + 2'd1)
endmodule
`default_nettype wire

// File: tb/tb_rotation_matrix_to_quaternion_core.sv
// Self-checking testbench for the rotation matrix to quaternion core.
`timescale 1ns / 1ps
`default_nettype none
module tb_rotation_matrix_to_quaternion_core;
	import rmq_pkg::*;

	localparam int LATENCY = 38;
	localparam int CYCLE_LIMIT = 400000;
	localparam longint QMAX = 131071;
	localparam longint QMIN = -131072;

	typedef struct {
		logic signed [FW-1:0] m [9];
	} matrix_t;

	typedef struct {
		logic signed [FW-1:0] qx, qy, qz, qw;
		logic sat;
	} quat_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic signed [FW-1:0] m00 = 0, m01 = 0, m02 = 0, m10 = 0, m11 = 0, m12 = 0,
		m20 = 0, m21 = 0, m22 = 0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [FW-1:0] qx, qy, qz, qw;
	logic saturated;

	matrix_t pending_matrices[$];
	quat_t expected_quats[$];
	int mismatches = 0;
	int words_sent = 0;
	int words_checked = 0;
	int sat_seen = 0;
	longint cycles = 0;
	bit stimulus_done = 0;

	rotation_matrix_to_quaternion_core dut (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint clamp_q(longint v, inout bit sat);
		if (v > QMAX) begin
			sat = 1'b1;
			return QMAX;
		end
		if (v < QMIN) begin
			sat = 1'b1;
			return QMIN;
		end
		return v;
	endfunction

	// Numerator times one half over the root, rounded half away from zero.
	function automatic longint scale_by_root(longint n, longint unsigned r, bit neg,
		inout bit sat);
		bit negres;
		longint unsigned mag, q;
		negres = (n < 0) != neg;
		if (r == 0) begin
			if (n == 0)
				return 0;
			sat = 1'b1;
			return negres ? QMIN : QMAX;
		end
		mag = longint'(n < 0 ? -n : n) << FRAC_BITS;
		q = (mag + r) / (2 * r);
		return clamp_q(negres ? -longint'(q) : longint'(q), sat);
	endfunction

	function automatic quat_t quat_from_matrix(matrix_t mx);
		longint a[9];
		longint one, tr, s, half;
		longint q[4];
		longint unsigned r;
		bit sat, neg;
		sel_t sel;
		quat_t res;
		one = longint'(1) << FRAC_BITS;
		sat = 1'b0;
		foreach (a[i])
			a[i] = longint'(mx.m[i]);
		tr = a[0] + a[4] + a[8];
		if (tr > 0) begin
			sel = SEL_W;
			s = tr + one;
		end else if (a[0] > a[4] && a[0] > a[8]) begin
			sel = SEL_X;
			s = one + a[0] - a[4] - a[8];
		end else if (a[4] > a[8]) begin
			sel = SEL_Y;
			s = one + a[4] - a[0] - a[8];
		end else begin
			sel = SEL_Z;
			s = one + a[8] - a[0] - a[4];
		end
		neg = sel != SEL_W;
		r = (s > 0) ? int_sqrt(longint'(s) << FRAC_BITS) : 64'd0;
		if (r == 0)
			sat = 1'b1;
		half = longint'(r >> 1);
		half = clamp_q(neg ? -half : half, sat);
		case (sel)
			SEL_W: begin
				q[3] = half;
				q[0] = scale_by_root(a[7] - a[5], r, neg, sat);
				q[1] = scale_by_root(a[2] - a[6], r, neg, sat);
				q[2] = scale_by_root(a[3] - a[1], r, neg, sat);
			end
			SEL_X: begin
				q[0] = half;
				q[1] = scale_by_root(a[3] + a[1], r, neg, sat);
				q[2] = scale_by_root(a[6] + a[2], r, neg, sat);
				q[3] = scale_by_root(a[7] - a[5], r, neg, sat);
			end
			SEL_Y: begin
				q[1] = half;
				q[0] = scale_by_root(a[3] + a[1], r, neg, sat);
				q[2] = scale_by_root(a[7] + a[5], r, neg, sat);
				q[3] = scale_by_root(a[2] - a[6], r, neg, sat);
			end
			default: begin
				q[2] = half;
				q[0] = scale_by_root(a[6] + a[2], r, neg, sat);
				q[1] = scale_by_root(a[7] + a[5], r, neg, sat);
				q[3] = scale_by_root(a[3] - a[1], r, neg, sat);
			end
		endcase
		res.qx = q[0][FW-1:0];
		res.qy = q[1][FW-1:0];
		res.qz = q[2][FW-1:0];
		res.qw = q[3][FW-1:0];
		res.sat = sat;
		return res;
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		mismatches++;
		$display("word %0d: %s got %0d expected %0d", words_checked, field, got, want);
	endtask

	function automatic logic signed [FW-1:0] rand_field();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? 18'sh1FFFF : 18'sh20000;
			1, 2: return $signed(18'($urandom_range(0, 131072))) - 18'sd65536;
			default: return 18'($urandom);
		endcase
	endfunction

	// Random fields, or mostly rotation-like matrices: a dominant diagonal entry picks each branch.
	function automatic matrix_t rand_matrix();
		matrix_t mx;
		int k;
		foreach (mx.m[i])
			mx.m[i] = rand_field();
		if ($urandom_range(0, 3) != 0) begin
			k = $urandom_range(0, 3);
			foreach (mx.m[i])
				mx.m[i] = $signed(18'($urandom_range(0, 131072))) - 18'sd65536;
			if (k == 3) begin
				mx.m[0] = FW'($urandom_range(0, 65536));
				mx.m[4] = FW'($urandom_range(0, 65536));
				mx.m[8] = FW'($urandom_range(0, 65536));
			end else begin
				mx.m[0] = -$signed(18'($urandom_range(0, 65536)));
				mx.m[4] = -$signed(18'($urandom_range(0, 65536)));
				mx.m[8] = -$signed(18'($urandom_range(0, 65536)));
				mx.m[k*4] = FW'($urandom_range(0, 65536));
			end
		end
		return mx;
	endfunction

	function automatic matrix_t diag_matrix(int d0, int d1, int d2, int off);
		matrix_t mx;
		foreach (mx.m[i])
			mx.m[i] = FW'(off);
		mx.m[0] = FW'(d0);
		mx.m[4] = FW'(d1);
		mx.m[8] = FW'(d2);
		return mx;
	endfunction

	initial begin
		matrix_t mx;
		pending_matrices.push_back(diag_matrix(65536, 65536, 65536, 0));
		pending_matrices.push_back(diag_matrix(65536, -65536, -65536, 0));
		pending_matrices.push_back(diag_matrix(-65536, 65536, -65536, 0));
		pending_matrices.push_back(diag_matrix(-65536, -65536, 65536, 0));
		// Ties on the diagonal with a non-positive trace.
		pending_matrices.push_back(diag_matrix(0, 0, 0, 1000));
		pending_matrices.push_back(diag_matrix(100, 100, -300, 5));
		pending_matrices.push_back(diag_matrix(-300, 100, 100, -5));
		pending_matrices.push_back(diag_matrix(100, -300, 100, 7));
		// Further diagonal matrices, several with entries at the field limits.
		pending_matrices.push_back(diag_matrix(-131072, 131071, 131071, 0));
		pending_matrices.push_back(diag_matrix(-65536, -65536, 0, 0));
		pending_matrices.push_back(diag_matrix(-65536, -65536, 0, 3));
		pending_matrices.push_back(diag_matrix(-131072, -131072, -131072, 131071));
		pending_matrices.push_back(diag_matrix(-131072, -131072, -131072, -131072));
		pending_matrices.push_back(diag_matrix(131071, 131071, 131071, 131071));
		pending_matrices.push_back(diag_matrix(131071, 131071, 131071, -131072));
		pending_matrices.push_back(diag_matrix(1, 0, 0, 0));
		// Small trace with large off-diagonal numerators to force clamping.
		mx = diag_matrix(1, 0, 0, 0);
		mx.m[7] = 131071; mx.m[5] = -131072; mx.m[2] = -131072; mx.m[6] = 131071;
		pending_matrices.push_back(mx);
		mx = diag_matrix(0, 0, -65536, 0);
		mx.m[1] = 131071; mx.m[3] = 131071; mx.m[2] = -131072; mx.m[6] = -131072;
		pending_matrices.push_back(mx);
		repeat (650)
			pending_matrices.push_back(rand_matrix());
		#64 arst_n = 1'b1;
	end

	// Sender: bursts of words separated by random gaps.
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk) begin
		matrix_t mx;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				words_sent++;
				expected_quats.push_back(quat_from_matrix(pending_matrices.pop_front()));
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_matrices.size() == 0) begin
					in_valid <= 1'b0;
					stimulus_done <= 1'b1;
				end else begin
					mx = pending_matrices[0];
					{m00, m01, m02} <= {mx.m[0], mx.m[1], mx.m[2]};
					{m10, m11, m12} <= {mx.m[3], mx.m[4], mx.m[5]};
					{m20, m21, m22} <= {mx.m[6], mx.m[7], mx.m[8]};
					in_valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end
			end
		end
	end

	// Receiver: stalls follow a pattern whose phase is chosen by bits 9:8 of the cycle counter.
	always @(posedge clk) begin
		quat_t want;
		if (arst_n) begin
			case (cycles[9:8])
				2'd0: out_ready <= 1'b1;
				2'd1: out_ready <= $urandom_range(0, 3) != 0;
				2'd2: out_ready <= cycles[2:0] == 3'd0;
				default: out_ready <= 1'($urandom_range(0, 1));
			endcase
			if (out_valid && out_ready) begin
				if (expected_quats.size() == 0) begin
					report_mismatch("unexpected word", 0, 0);
				end else begin
					want = expected_quats.pop_front();
					if (qx !== want.qx) report_mismatch("qx", qx, want.qx);
					if (qy !== want.qy) report_mismatch("qy", qy, want.qy);
					if (qz !== want.qz) report_mismatch("qz", qz, want.qz);
					if (qw !== want.qw) report_mismatch("qw", qw, want.qw);
					if (saturated !== want.sat)
						report_mismatch("saturated", saturated, want.sat);
				end
				if (saturated === 1'b1)
					sat_seen++;
				words_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		wait (stimulus_done);
		wait (expected_quats.size() == 0);
		repeat (LATENCY * 3) @(posedge clk);
		if (expected_quats.size() != 0)
			report_mismatch("words left over", expected_quats.size(), 0);
		$display("Sent %0d matrices, checked %0d quaternions, %0d of them saturated.",
			words_sent, words_checked, sat_seen);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
`default_nettype wire
